### rtl/fpa_pkg.sv
// fpa_pkg: shared types, constants and saturation helpers for the fixed-point alu
// used by fpa_front, fpa_div and fixed_point_alu
`timescale 1ns / 1ps
package fpa_pkg;

  localparam int WordBits = 32;
  localparam int FracBits = 8;
  // dividend is the operand magnitude shifted up by the fraction width
  localparam int QuotBits = WordBits + FracBits;
  localparam int ProdBits = 2 * WordBits;

  typedef logic signed [WordBits-1:0] word_t;
  typedef logic [WordBits-1:0]        mag_t;
  typedef logic [QuotBits-1:0]        quo_t;
  typedef logic [ProdBits-1:0]        wide_t;

  typedef enum logic [3:0] {
    FnAdd     = 4'd0,
    FnSub     = 4'd1,
    FnMul     = 4'd2,
    FnDiv     = 4'd3,
    FnMin     = 4'd4,
    FnMax     = 4'd5,
    FnInc     = 4'd6,
    FnDec     = 4'd7,
    FnFromInt = 4'd8,
    FnToInt   = 4'd9,
    FnCmp     = 4'd10
  } func_e;

  // per-word sideband carried alongside the divider
  typedef struct packed {
    func_e op;
    word_t res;
    logic  ov;
    logic  dz;
    logic  neg;
    logic  gt;
    logic  lt;
    logic  eq;
  } side_t;

  typedef struct packed {
    word_t res;
    logic  ov;
  } sat_t;

  localparam word_t MaxWord = {1'b0, {(WordBits-1){1'b1}}};
  localparam word_t MinWord = {1'b1, {(WordBits-1){1'b0}}};

  // absolute value of a signed word, fits unsigned word
  function automatic mag_t magnitude(word_t v);
    mag_t m;
    m = v[WordBits-1] ? (mag_t'(0) - mag_t'(v)) : mag_t'(v);
    return m;
  endfunction

  // saturate a sign/magnitude value to the signed word range
  function automatic sat_t sat_mag(logic neg, wide_t m);
    sat_t  s;
    wide_t lim;
    lim = wide_t'(mag_t'(MaxWord)) + wide_t'(neg);
    if (m > lim) begin
      s.ov  = 1'b1;
      s.res = neg ? MinWord : MaxWord;
    end else begin
      s.ov  = 1'b0;
      s.res = neg ? word_t'(mag_t'(0) - m[WordBits-1:0]) : word_t'(m[WordBits-1:0]);
    end
    return s;
  endfunction

  // saturate a one-bit-wider signed sum to the word range
  function automatic sat_t sat_signed(logic [WordBits:0] v);
    sat_t s;
    if (v[WordBits] != v[WordBits-1]) begin
      s.ov  = 1'b1;
      s.res = v[WordBits] ? MinWord : MaxWord;
    end else begin
      s.ov  = 1'b0;
      s.res = word_t'(v[WordBits-1:0]);
    end
    return s;
  endfunction

endpackage

### rtl/fpa_front.sv
// fpa_front: first pipeline stage, opcode decode, simple ops, compare flags, magnitudes
// depends on fpa_pkg
`timescale 1ns / 1ps
module fpa_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [3:0]            func_i,
  input  fpa_pkg::word_t        a_raw_i,
  input  fpa_pkg::word_t        b_raw_i,
  output logic                  valid_o,
  output fpa_pkg::side_t        side_o,
  output fpa_pkg::mag_t         ma_o,
  output fpa_pkg::mag_t         mb_o
);

  fpa_pkg::func_e                 op;
  fpa_pkg::side_t                 side_d, side_q;
  fpa_pkg::sat_t                  st;
  fpa_pkg::mag_t                  ma_d, mb_d, ma_q, mb_q;
  logic [fpa_pkg::WordBits:0]     a_ext, b_ext;
  logic                           valid_q;

  assign op    = fpa_pkg::func_e'(func_i);
  assign a_ext = {a_raw_i[fpa_pkg::WordBits-1], a_raw_i};
  assign b_ext = {b_raw_i[fpa_pkg::WordBits-1], b_raw_i};
  assign ma_d  = fpa_pkg::magnitude(a_raw_i);
  assign mb_d  = fpa_pkg::magnitude(b_raw_i);

  // operations completed in this stage, divide-by-zero detection and saturation
  always_comb begin
    st.res = '0;
    st.ov  = 1'b0;
    side_d.dz = 1'b0;
    unique case (op)
      fpa_pkg::FnAdd:     st = fpa_pkg::sat_signed(a_ext + b_ext);
      fpa_pkg::FnSub:     st = fpa_pkg::sat_signed(a_ext - b_ext);
      fpa_pkg::FnInc:     st = fpa_pkg::sat_signed(a_ext + (fpa_pkg::WordBits+1)'(1));
      fpa_pkg::FnDec:     st = fpa_pkg::sat_signed(a_ext - (fpa_pkg::WordBits+1)'(1));
      fpa_pkg::FnMin:     st.res = (a_raw_i < b_raw_i) ? a_raw_i : b_raw_i;
      fpa_pkg::FnMax:     st.res = (a_raw_i > b_raw_i) ? a_raw_i : b_raw_i;
      fpa_pkg::FnFromInt: st = fpa_pkg::sat_mag(a_raw_i[fpa_pkg::WordBits-1],
                                  fpa_pkg::wide_t'(ma_d) << fpa_pkg::FracBits);
      fpa_pkg::FnToInt:   st.res = a_raw_i >>> fpa_pkg::FracBits;
      fpa_pkg::FnDiv: begin
        if (b_raw_i == '0) begin
          side_d.dz = 1'b1;
          st.res = a_raw_i[fpa_pkg::WordBits-1] ? fpa_pkg::MinWord : fpa_pkg::MaxWord;
        end
      end
      default: st.res = '0;
    endcase
    side_d.op  = op;
    side_d.res = st.res;
    side_d.ov  = st.ov;
    side_d.neg = a_raw_i[fpa_pkg::WordBits-1] ^ b_raw_i[fpa_pkg::WordBits-1];
    side_d.gt  = a_raw_i > b_raw_i;
    side_d.lt  = a_raw_i < b_raw_i;
    side_d.eq  = a_raw_i == b_raw_i;
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_d;
      ma_q   <= ma_d;
      mb_q   <= mb_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign ma_o    = ma_q;
  assign mb_o    = mb_q;

endmodule

### rtl/fpa_div.sv
// fpa_div: pipelined restoring divider, one quotient bit per stage
// depends on fpa_pkg
`timescale 1ns / 1ps
module fpa_div (
  input  logic           clk_i,
  input  logic           en_i,
  input  fpa_pkg::quo_t  num_i,
  input  fpa_pkg::mag_t  den_i,
  output fpa_pkg::quo_t  quo_o,
  output fpa_pkg::mag_t  rem_o,
  output fpa_pkg::mag_t  den_o
);

  localparam int Depth = fpa_pkg::QuotBits;

  fpa_pkg::quo_t num_q [1:Depth];
  fpa_pkg::quo_t quo_q [1:Depth];
  fpa_pkg::mag_t rem_q [1:Depth];
  fpa_pkg::mag_t den_q [1:Depth];
  fpa_pkg::quo_t num_d [1:Depth];
  fpa_pkg::quo_t quo_d [1:Depth];
  fpa_pkg::mag_t rem_d [1:Depth];
  fpa_pkg::mag_t den_d [1:Depth];

  // one trial subtract per stage
  always_comb begin
    fpa_pkg::quo_t              num_in, quo_in;
    fpa_pkg::mag_t              rem_in, den_in;
    logic [fpa_pkg::WordBits:0] trial;
    logic                       ge;
    for (int k = 1; k <= Depth; k++) begin
      if (k == 1) begin
        num_in = num_i;
        quo_in = '0;
        rem_in = '0;
        den_in = den_i;
      end else begin
        num_in = num_q[k-1];
        quo_in = quo_q[k-1];
        rem_in = rem_q[k-1];
        den_in = den_q[k-1];
      end
      trial    = {rem_in, num_in[Depth-1]};
      ge       = trial >= {1'b0, den_in};
      num_d[k] = num_in << 1;
      quo_d[k] = {quo_in[Depth-2:0], ge};
      rem_d[k] = ge ? fpa_pkg::WordBits'(trial - {1'b0, den_in})
                    : trial[fpa_pkg::WordBits-1:0];
      den_d[k] = den_in;
    end
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 1; k <= Depth; k++) begin
        num_q[k] <= num_d[k];
        quo_q[k] <= quo_d[k];
        rem_q[k] <= rem_d[k];
        den_q[k] <= den_d[k];
      end
    end
  end

  assign quo_o = quo_q[Depth];
  assign rem_o = rem_q[Depth];
  assign den_o = den_q[Depth];

endmodule

### rtl/fixed_point_alu.sv
// fixed_point_alu: signed q24.8 alu; front stage, divider stages, then output register
// one word per cycle unless stalled; depth is set by the 40-stage bit-per-stage divider
// all operations share that pipeline, which stalls as a whole when the output is held
// reset clears the valid bits only; no clearing pass, ready right after reset
// depends on fpa_pkg, fpa_front, fpa_div
`timescale 1ns / 1ps
module fixed_point_alu (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [3:0]            func_i,
  input  fpa_pkg::word_t        a_raw_i,
  input  fpa_pkg::word_t        b_raw_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output fpa_pkg::word_t        result_raw_o,
  output logic                  greater_o,
  output logic                  less_o,
  output logic                  equal_o,
  output logic                  overflow_o,
  output logic                  div_zero_o
);

  localparam int Depth = fpa_pkg::QuotBits;

  logic                       en;
  logic                       s1_valid;
  fpa_pkg::side_t             s1_side;
  fpa_pkg::mag_t              s1_ma, s1_mb;
  fpa_pkg::quo_t              div_quo;
  fpa_pkg::mag_t              div_rem, div_den;
  logic                       vld_q [1:Depth];
  fpa_pkg::side_t             side_q [1:Depth];
  fpa_pkg::side_t             side2_d;
  fpa_pkg::wide_t             prod_q;
  fpa_pkg::wide_t             prod_rnd;
  fpa_pkg::sat_t              mul_sat, div_sat, fin;
  logic                       div_up;
  logic [fpa_pkg::QuotBits:0] div_round;
  fpa_pkg::side_t             last;
  logic                       out_valid_q;
  fpa_pkg::word_t             res_q;
  logic                       gt_q, lt_q, eq_q, ov_q, dz_q;

  // whole pipeline advances unless the output word is held
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  fpa_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .func_i  (func_i),
    .a_raw_i (a_raw_i),
    .b_raw_i (b_raw_i),
    .valid_o (s1_valid),
    .side_o  (s1_side),
    .ma_o    (s1_ma),
    .mb_o    (s1_mb)
  );

  fpa_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({s1_ma, {fpa_pkg::FracBits{1'b0}}}),
    .den_i (s1_mb),
    .quo_o (div_quo),
    .rem_o (div_rem),
    .den_o (div_den)
  );

  // multiply rounding, half away from zero on the magnitude
  assign prod_rnd = prod_q + (fpa_pkg::wide_t'(1) << (fpa_pkg::FracBits - 1));
  assign mul_sat  = fpa_pkg::sat_mag(side_q[1].neg, prod_rnd >> fpa_pkg::FracBits);

  // second sideband stage picks up the multiply result
  always_comb begin
    side2_d = side_q[1];
    if (side_q[1].op == fpa_pkg::FnMul) begin
      side2_d.res = mul_sat.res;
      side2_d.ov  = mul_sat.ov;
    end
  end

  // sideband valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= Depth; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_q[1] <= s1_valid;
      for (int k = 2; k <= Depth; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // sideband payload, multiplier and its rounding stage
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[1] <= s1_side;
      prod_q    <= s1_ma * s1_mb;
      side_q[2] <= side2_d;
      for (int k = 3; k <= Depth; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // divide rounding: bump when twice the remainder reaches the divisor
  assign last      = side_q[Depth];
  assign div_up    = {div_rem, 1'b0} >= {1'b0, div_den};
  assign div_round = {1'b0, div_quo} + (fpa_pkg::QuotBits+1)'(div_up);
  assign div_sat   = fpa_pkg::sat_mag(last.neg, fpa_pkg::wide_t'(div_round));

  always_comb begin
    if (last.op == fpa_pkg::FnDiv && !last.dz) begin
      fin = div_sat;
    end else begin
      fin.res = last.res;
      fin.ov  = last.ov;
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[Depth];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= fin.res;
      ov_q  <= fin.ov;
      dz_q  <= last.dz;
      gt_q  <= last.gt;
      lt_q  <= last.lt;
      eq_q  <= last.eq;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign result_raw_o = res_q;
  assign greater_o    = gt_q;
  assign less_o       = lt_q;
  assign equal_o      = eq_q;
  assign overflow_o   = ov_q;
  assign div_zero_o   = dz_q;

  // checks
  a_ov_dz_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(overflow_o && div_zero_o))
    else $error("overflow and divide by zero both set");

  a_cmp_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot({greater_o, less_o, equal_o}))
    else $error("compare flags not one-hot");

  a_dz_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && div_zero_o) |->
      (result_raw_o == fpa_pkg::MaxWord || result_raw_o == fpa_pkg::MinWord))
    else $error("divide by zero result not at a limit");

  a_ov_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |->
      (result_raw_o == fpa_pkg::MaxWord || result_raw_o == fpa_pkg::MinWord))
    else $error("overflow result not saturated");

endmodule
